@@ hdl/rrg_pkg.sv @@
// Shared payload types for the rational reduction block.
`default_nettype none

package rrg_pkg;

  // Width of the signed fields on both channels.
  localparam int FIELD_W = 64;
  // Width of the reduced denominator field.
  localparam int DEN_W = 63;

  // One request: a signed fraction.
  typedef struct packed {
    logic signed [FIELD_W-1:0] num_in;
    logic signed [FIELD_W-1:0] den_in;
  } rrg_in_t;

  // One result: the fraction in lowest terms.
  typedef struct packed {
    logic signed [FIELD_W-1:0] num_out;
    logic [DEN_W-1:0]          den_out;
  } rrg_out_t;

endpackage

`default_nettype wire

@@ hdl/rrg_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module rrg_div #(
  parameter int MAG_W = 63
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] dividend,
  input  wire logic [MAG_W-1:0] divisor,
  output logic                  done,
  output logic [MAG_W-1:0]      quotient,
  output logic [MAG_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] dvsr;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, quo[MAG_W-1]};
    diff    = shifted - {1'b0, dvsr};
  end

  // Control: a start loads the operands, then MAG_W steps run.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register shifts the dividend out as bits come in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      if (!diff[MAG_W]) begin
        rem <= diff[MAG_W-1:0];
        quo <= {quo[MAG_W-2:0], 1'b1};
      end else begin
        rem <= shifted[MAG_W-1:0];
        quo <= {quo[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

@@ hdl/rational_reduce_gcd.sv @@
// Work: E Euclid remainder steps (E is 1 to about 1.44*WIDTH) and two quotient divisions
// run in one shared restoring divider before the result enters the output register.
// Throughput: one request in work at a time; the next is taken in the cycle after the result
// enters the output register, even while that result is still stalled.
// Reset (synchronous, active high) returns the sequencer to idle and drops the output valid.
`default_nettype none

module rational_reduce_gcd #(
  parameter int WIDTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire rrg_pkg::rrg_in_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output rrg_pkg::rrg_out_t    out_data
);

  import rrg_pkg::*;

  localparam int MAG_W = WIDTH - 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_GCD_CHK  = 3'd1;
  localparam logic [2:0] S_GCD_WAIT = 3'd2;
  localparam logic [2:0] S_QN       = 3'd3;
  localparam logic [2:0] S_QD       = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [MAG_W-1:0] num_mag;
  logic [MAG_W-1:0] den_mag;
  logic [MAG_W-1:0] a;
  logic [MAG_W-1:0] b;
  logic [MAG_W-1:0] qn;
  logic [MAG_W-1:0] qd;
  logic             sign_neg;

  logic [WIDTH-1:0] num_raw;
  logic [WIDTH-1:0] den_raw;
  logic [WIDTH-1:0] num_neg_val;
  logic [WIDTH-1:0] den_neg_val;
  logic [MAG_W-1:0] num_mag_in;
  logic [MAG_W-1:0] den_mag_in;
  logic             den_zero;

  logic             div_start;
  logic [MAG_W-1:0] div_dividend;
  logic [MAG_W-1:0] div_divisor;
  logic             div_done;
  logic [MAG_W-1:0] div_quo;
  logic [MAG_W-1:0] div_rem;

  logic             accept;
  logic             out_free;
  logic [FIELD_W-1:0] qn_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Saturated magnitudes of the low WIDTH bits of each operand.
  always_comb begin
    num_raw     = in_data.num_in[WIDTH-1:0];
    den_raw     = in_data.den_in[WIDTH-1:0];
    num_neg_val = num_raw[WIDTH-1] ? (WIDTH'(0) - num_raw) : num_raw;
    den_neg_val = den_raw[WIDTH-1] ? (WIDTH'(0) - den_raw) : den_raw;
    num_mag_in  = num_neg_val[WIDTH-1] ? {MAG_W{1'b1}} : num_neg_val[MAG_W-1:0];
    den_mag_in  = den_neg_val[WIDTH-1] ? {MAG_W{1'b1}} : den_neg_val[MAG_W-1:0];
    den_zero    = (den_mag_in == '0);
  end

  // Sequencer: Euclid remainders, then the two quotients by the divisor.
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = a;
    div_divisor  = b;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_GCD_CHK;
      end
      S_GCD_CHK: begin
        div_start = 1'b1;
        if (b == '0) begin
          div_dividend = num_mag;
          div_divisor  = a;
          state_next   = S_QN;
        end else begin
          state_next = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (div_done) state_next = S_GCD_CHK;
      end
      S_QN: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = den_mag;
          div_divisor  = a;
          state_next   = S_QD;
        end
      end
      S_QD: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (den_zero) begin
        num_mag  <= '0;
        den_mag  <= MAG_W'(1);
        a        <= '0;
        b        <= MAG_W'(1);
        sign_neg <= 1'b0;
      end else begin
        num_mag  <= num_mag_in;
        den_mag  <= den_mag_in;
        a        <= num_mag_in;
        b        <= den_mag_in;
        sign_neg <= num_raw[WIDTH-1] ^ den_raw[WIDTH-1];
      end
    end else if (state == S_GCD_WAIT && div_done) begin
      a <= b;
      b <= div_rem;
    end
    if (state == S_QN && div_done) begin
      qn <= div_quo;
    end
    if (state == S_QD && div_done) begin
      qd <= div_quo;
    end
  end

  rrg_div #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Output register: the sign goes to the numerator unless it is zero.
  assign qn_ext = FIELD_W'(qn);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data.num_out <= (sign_neg && (qn != '0)) ? (FIELD_W'(0) - qn_ext) : qn_ext;
      out_data.den_out <= DEN_W'(qd);
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_rational_reduce_gcd.sv @@
// Self-checking testbench for the rational_reduce_gcd fraction reducer.
`default_nettype none

module tb_rational_reduce_gcd;
  timeunit 1ns;
  timeprecision 1ps;

  import rrg_pkg::*;

  localparam int          N_REQUESTS   = 1950;
  localparam int          QUIET_LIMIT  = 40000;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          HOLD_AT      = 40;
  localparam int          CALM_TAIL    = 150;
  localparam int          TAIL_CYCLES  = 200;
  localparam logic [63:0] MAX_MAG      = 64'h7fff_ffff_ffff_ffff;

  // A queued request, optionally held back until the block has drained.
  typedef struct {
    rrg_in_t fraction;
    bit      drain_first;
  } pending_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rrg_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rrg_out_t out_data;

  pending_t fraction_q[$];
  rrg_out_t reduced_q[$];

  int  n_total = N_REQUESTS;
  int  n_taken = 0;
  int  n_results = 0;
  int  n_errors = 0;
  int  n_zero_den = 0;
  int  n_common = 0;
  int  n_negative = 0;
  int  n_in_stalled = 0;
  int  quiet_cycles = 0;
  bit  req_taken = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic idle_on;

  rational_reduce_gcd #(.WIDTH(64)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Idling alternates on and off every 64 requests and stops near the end.
  assign idle_on = (n_taken < n_total - CALM_TAIL) && ((n_taken / 64) % 2 == 0);

  // Expected result of one request: magnitudes, Euclid, division, sign to numerator.
  function automatic rrg_out_t reduce_fraction(rrg_in_t req);
    logic [63:0] num_mag, den_mag, a, b, r, g, qn, qd;
    logic        num_neg, den_neg;
    rrg_out_t    res;
    num_neg = req.num_in[63];
    den_neg = req.den_in[63];
    num_mag = num_neg ? 64'd0 - req.num_in : req.num_in;
    den_mag = den_neg ? 64'd0 - req.den_in : req.den_in;
    if (num_mag > MAX_MAG) num_mag = MAX_MAG;
    if (den_mag > MAX_MAG) den_mag = MAX_MAG;
    if (den_mag == 64'd0) begin
      num_mag = 64'd0;
      den_mag = 64'd1;
      num_neg = 1'b0;
      den_neg = 1'b0;
    end
    a = num_mag;
    b = den_mag;
    if (a == 64'd0) begin
      g = (b == 64'd0) ? 64'd1 : b;
    end else if (b == 64'd0) begin
      g = a;
    end else begin
      while (b != 64'd0) begin
        r = a % b;
        a = b;
        b = r;
      end
      g = a;
    end
    qn = num_mag / g;
    qd = den_mag / g;
    res.num_out = ((num_neg != den_neg) && qn != 64'd0) ? 64'd0 - qn : qn;
    res.den_out = qd[62:0];
    return res;
  endfunction

  // Random magnitude of at most the given number of bits (0 to 63).
  function automatic logic [63:0] rand_mag(int unsigned bits);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (bits == 0) return 64'd0;
    return v & ((64'd1 << bits) - 64'd1);
  endfunction

  // Random sign applied to a magnitude.
  function automatic logic [63:0] rand_sign(logic [63:0] mag);
    return $urandom_range(0, 1) ? 64'd0 - mag : mag;
  endfunction

  task automatic queue_request(input logic [63:0] num, input logic [63:0] den,
                               input bit drain_first);
    pending_t p;
    p.fraction.num_in = num;
    p.fraction.den_in = den;
    p.drain_first = drain_first;
    fraction_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < 20)
      $display("result %0d %s: got %0d expected %0d", n_results, what,
               $signed(got), $signed(want));
    n_errors++;
  endtask

  // Sender: offers queued requests, with random gaps and a drain pause when marked.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (fraction_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (fraction_q[0].drain_first && reduced_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 4);
      end else begin
        in_data  <= fraction_q[0].fraction;
        in_valid <= 1'b1;
        fraction_q.pop_front();
      end
    end
  end

  // Receiver: short random stall bursts, plus one long hold-off once HOLD_AT results are in.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (recv_gap > 0) begin
      out_stall <= 1'b1;
      recv_gap  <= recv_gap - 1;
    end else if (idle_on && $urandom_range(0, out_valid ? 3 : 63) == 0) begin
      out_stall <= 1'b1;
      recv_gap  <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    rrg_out_t    want;
    logic [63:0] den_abs;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && in_stall) n_in_stalled++;
      if (in_valid && !in_stall) begin
        want = reduce_fraction(in_data);
        reduced_q.push_back(want);
        n_taken++;
        den_abs = in_data.den_in[63] ? 64'd0 - in_data.den_in : in_data.den_in;
        if (in_data.den_in == 64'd0) n_zero_den++;
        else if (den_abs != {1'b0, want.den_out}) n_common++;
        if (want.num_out[63]) n_negative++;
      end
      if (out_valid && !out_stall) begin
        if (reduced_q.size() == 0) begin
          if (n_errors < 20)
            $display("result %0d arrived with no request outstanding", n_results);
          n_errors++;
        end else begin
          want = reduced_q.pop_front();
          if (out_data.num_out !== want.num_out)
            report_mismatch("num_out", out_data.num_out, want.num_out);
          if (out_data.den_out !== want.den_out)
            report_mismatch("den_out", {1'b0, out_data.den_out}, {1'b0, want.den_out});
        end
        n_results++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("rational_reduce_gcd: mismatch");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [63:0] fa, fb, ft, g, a, b;
    int unsigned gb, kind;

    // Directed: zero cases, extremes, signs, coprime and worst-case Euclid chains.
    queue_request(64'd0, 64'd0, 1'b0);
    queue_request(64'd5, 64'd0, 1'b0);
    queue_request(64'd0 - MAX_MAG, 64'd0, 1'b0);
    queue_request(64'd0, 64'd7, 1'b0);
    queue_request(64'd0, 64'd0 - MAX_MAG, 1'b0);
    queue_request(MAX_MAG, MAX_MAG, 1'b0);
    queue_request(64'd0 - MAX_MAG, MAX_MAG, 1'b0);
    queue_request(MAX_MAG, 64'd0 - MAX_MAG, 1'b0);
    queue_request(64'd0 - MAX_MAG, 64'd0 - MAX_MAG, 1'b0);
    queue_request(MAX_MAG, 64'd1, 1'b0);
    queue_request(64'd1, MAX_MAG, 1'b0);
    queue_request(64'd0 - 64'd1, 64'd0 - MAX_MAG, 1'b0);
    queue_request(64'd6, 64'd0 - 64'd4, 1'b0);
    queue_request(64'd0 - 64'd6, 64'd0 - 64'd4, 1'b0);
    queue_request(64'd12, 64'd18, 1'b0);
    queue_request(64'd0 - 64'd1, 64'd1, 1'b0);
    queue_request(64'd1, 64'd0 - 64'd1, 1'b0);
    queue_request(64'd1 << 62, 64'd1 << 40, 1'b0);
    queue_request(MAX_MAG, MAX_MAG - 64'd1, 1'b0);
    queue_request(MAX_MAG - 64'd1, 64'd0 - 64'd2, 1'b0);
    fa = 64'd1;
    fb = 64'd1;
    repeat (90) begin
      ft = fa + fb;
      fa = fb;
      fb = ft;
    end
    queue_request(fa, fb, 1'b0);
    queue_request(64'd0 - fb, fa, 1'b0);

    // A run of small fractions so the long output hold-off fills the block quickly.
    repeat (70)
      queue_request(rand_sign(rand_mag($urandom_range(1, 10))),
                    rand_sign(rand_mag($urandom_range(1, 10))), 1'b0);

    // Random mix: shared factors, independent values, zeros and tiny values.
    while (fraction_q.size() < N_REQUESTS) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        gb = $urandom_range(1, 20);
        g = rand_mag(gb);
        if (g == 64'd0) g = 64'd1;
        a = rand_mag($urandom_range(0, 62 - gb));
        b = rand_mag($urandom_range(1, 62 - gb));
        fa = rand_sign(g * a);
        fb = rand_sign(g * b);
      end else if (kind < 80) begin
        fa = rand_sign(rand_mag($urandom_range(1, 63)));
        fb = rand_sign(rand_mag($urandom_range(1, 63)));
      end else if (kind < 90) begin
        fa = rand_sign(rand_mag($urandom_range(0, 63)));
        fb = rand_sign(rand_mag($urandom_range(0, 63)));
        if ($urandom_range(0, 1)) fa = 64'd0;
        else fb = 64'd0;
      end else begin
        fa = rand_sign(rand_mag($urandom_range(0, 8)));
        fb = rand_sign(rand_mag($urandom_range(0, 8)));
      end
      queue_request(fa, fb,
                    fraction_q.size() == 500 || fraction_q.size() == 1200);
    end
    n_total = fraction_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (n_taken < n_total || reduced_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("reduced %0d fractions: %0d with zero denominator, %0d with a common factor,",
             n_taken, n_zero_den, n_common);
    $display("%0d negative results; input held back on %0d cycles", n_negative,
             n_in_stalled);
    if (n_errors == 0 && reduced_q.size() == 0) begin
      $display("rational_reduce_gcd: match");
    end else begin
      $display("rational_reduce_gcd: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
